/* rtl/sjsf_pkg.sv */
// Package with the shared types, constants and helpers of the jump smoothing filter.
`default_nettype none

package sjsf_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_FILTER_STRENGTH = 2'd0,
    REG_JUMP_THRESHOLD  = 2'd1,
    REG_FULL_SCALE      = 2'd2
  } reg_index_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_SCALE,
    ST_DIV_SCALE,
    ST_SET_LEN,
    ST_MUL_RAMP,
    ST_DIV_RAMP,
    ST_FINISH
  } state_t;

  // Register reset values and the strength ceiling.
  localparam logic [6:0]  STRENGTH_RESET       = 7'd0;
  localparam logic [15:0] JUMP_THRESHOLD_RESET = 16'd10;
  localparam logic [15:0] FULL_SCALE_RESET     = 16'd1000;
  localparam logic [6:0]  STRENGTH_MAX         = 7'd100;

  // Datapath geometry: full ramp product width, width of strength times range, ramp length and step widths.
  localparam int DIVIDEND_BITS = 63;
  localparam int SCALE_BITS    = 22;
  localparam int LEN_BITS      = 17;
  localparam int STEP_BITS     = 31;

  // Percent division by reciprocal: x / 100 equals (x * RECIP_100) >> RECIP_SHIFT
  // for every strength-times-range product below 2^SCALE_BITS.
  localparam int          RECIP_SHIFT = 29;
  localparam logic [22:0] RECIP_100   = 23'd5368710;

  // Saturate a 36-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh0_7FFF_FFFF;
    lo = -36'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/soc_jump_smoothing_filter_core.sv */
// Top level of the state-of-charge jump smoothing filter with its serial datapath.
// A sample without a new jump passes EVAL, MUL_RAMP, the ramp division and FINISH;
// a jump that starts a new ramp adds MUL_SCALE, DIV_SCALE and SET_LEN (percent scaling
// by multiply and reciprocal). One transaction is in flight at a time; the ramp division
// runs one bit per cycle (63 steps); FINISH waits while the output register is full.
// A new input is taken while a finished result still waits in the output register.
// Reset (synchronous, active high) restores register defaults and clears the filter state.
`default_nettype none

module soc_jump_smoothing_filter_core
  import sjsf_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_write,
  input  wire [1:0]              cfg_index,
  input  wire [15:0]             cfg_data,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [SAMPLE_BITS-1:0]  soc_sample,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic signed [31:0]     smoothed_soc,
  output logic signed [31:0]     offset_now
);

  // Configuration registers.
  logic [6:0]  filter_strength;
  logic [15:0] jump_threshold;
  logic [15:0] full_scale;

  // Filter state.
  logic [SAMPLE_BITS-1:0]  previous_sample;
  logic signed [31:0]      offset_value;
  logic signed [31:0]      jump_amount;
  logic [LEN_BITS-1:0]     ramp_length;
  logic [STEP_BITS-1:0]    ramp_step;

  // Per-transaction working registers.
  logic [SAMPLE_BITS-1:0]  sample;
  logic                    delta_nz;
  logic [14:0]             range;
  logic [DIVIDEND_BITS-1:0] div_q;
  logic [LEN_BITS-1:0]     div_rem;
  logic [LEN_BITS-1:0]     div_d;
  logic [5:0]              div_cnt;

  state_t state, state_next;

  // Sample arithmetic in 34-bit signed.
  logic signed [33:0] sample_s;
  logic signed [33:0] delta;
  logic signed [33:0] abs_delta;
  logic signed [33:0] headroom_full;
  logic signed [33:0] range_min;
  logic signed [33:0] range_val;
  logic               jump_hit;
  logic [6:0]         strength_eff;

  always_comb begin
    sample_s      = $signed(34'(sample));
    delta         = sample_s - $signed(34'(previous_sample));
    abs_delta     = delta[33] ? -delta : delta;
    strength_eff  = (filter_strength > STRENGTH_MAX) ? STRENGTH_MAX : filter_strength;
    jump_hit      = (abs_delta > $signed(34'(jump_threshold))) && (strength_eff != 7'd0);
    headroom_full = $signed(34'(full_scale)) - sample_s;
    range_min     = (sample_s < headroom_full) ? sample_s : headroom_full;
    if (range_min < 34'sd1) begin
      range_min = 34'sd1;
    end
    range_val     = (abs_delta < range_min) ? abs_delta : range_min;
  end

  // Shared multiplier: percent scaling, reciprocal division by 100 or ramp product.
  logic [31:0]              jump_mag;
  logic [31:0]              mul_a;
  logic [STEP_BITS-1:0]     mul_b;
  logic [DIVIDEND_BITS-1:0] product;

  always_comb begin
    jump_mag = jump_amount[31] ? (~jump_amount + 32'd1) : jump_amount;
    if (state == ST_MUL_SCALE) begin
      mul_a = 32'(strength_eff);
      mul_b = STEP_BITS'(range);
    end else if (state == ST_DIV_SCALE) begin
      mul_a = 32'(div_q[SCALE_BITS-1:0]);
      mul_b = STEP_BITS'(RECIP_100);
    end else begin
      mul_a = jump_mag;
      mul_b = ramp_step;
    end
    product = DIVIDEND_BITS'(mul_a) * DIVIDEND_BITS'(mul_b);
  end

  // One restoring division step per cycle.
  logic [LEN_BITS:0]   div_trial;
  logic                div_ge;
  logic [LEN_BITS-1:0] div_rem_next;

  always_comb begin
    div_trial    = {div_rem, div_q[DIVIDEND_BITS-1]};
    div_ge       = div_trial >= {1'b0, div_d};
    div_rem_next = div_ge ? LEN_BITS'(div_trial - {1'b0, div_d}) : LEN_BITS'(div_trial);
  end

  // Final offset, smoothed value and ramp bookkeeping.
  logic [33:0]           quot_clamp;
  logic signed [35:0]    quot_signed;
  logic signed [31:0]    offset_fin;
  logic signed [31:0]    smoothed_fin;
  logic signed [35:0]    smooth_diff;
  logic                  ramp_done;
  logic                  step_inc;
  logic [STEP_BITS-1:0]  step_base;
  logic [STEP_BITS-1:0]  step_fin;
  logic [LEN_BITS-1:0]   scaled_len;

  always_comb begin
    quot_clamp   = (|div_q[DIVIDEND_BITS-1:33]) ? 34'h2_0000_0000 : {1'b0, div_q[32:0]};
    quot_signed  = jump_amount[31] ? -$signed(36'(quot_clamp)) : $signed(36'(quot_clamp));
    offset_fin   = sat32(36'(jump_amount) - quot_signed);
    smoothed_fin = sat32($signed(36'(sample)) - 36'(offset_fin));
    smooth_diff  = 36'(smoothed_fin) - $signed(36'(sample));
    ramp_done    = (32'(ramp_step) > 32'(ramp_length)) && (jump_amount > 32'sd1);
    step_inc     = ((smooth_diff > 36'sd1) || (smooth_diff < -36'sd1)) && delta_nz;
    step_base    = ramp_done ? '0 : ramp_step;
    step_fin     = (step_inc && !(&step_base)) ? step_base + STEP_BITS'(1) : step_base;
    scaled_len   = (div_q[SCALE_BITS-1:0] == '0) ? LEN_BITS'(1)
                                                 : LEN_BITS'(div_q[SCALE_BITS-1:0]);
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and input handshake.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = jump_hit ? ST_MUL_SCALE : ST_MUL_RAMP;
      end
      ST_MUL_SCALE: begin
        state_next = ST_DIV_SCALE;
      end
      ST_DIV_SCALE: begin
        state_next = ST_SET_LEN;
      end
      ST_SET_LEN: begin
        state_next = ST_MUL_RAMP;
      end
      ST_MUL_RAMP: begin
        state_next = ST_DIV_RAMP;
      end
      ST_DIV_RAMP: begin
        if (div_cnt == 6'd1) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_strength <= STRENGTH_RESET;
      jump_threshold  <= JUMP_THRESHOLD_RESET;
      full_scale      <= FULL_SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER_STRENGTH: filter_strength <= cfg_data[6:0];
        REG_JUMP_THRESHOLD:  jump_threshold  <= cfg_data;
        REG_FULL_SCALE:      full_scale      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Filter state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      offset_value    <= '0;
      jump_amount     <= '0;
      ramp_length     <= LEN_BITS'(1);
      ramp_step       <= '0;
    end else begin
      case (state)
        ST_EVAL: begin
          if (jump_hit) begin
            ramp_step   <= '0;
            jump_amount <= sat32(36'(delta) + 36'(offset_value));
          end
        end
        ST_SET_LEN: begin
          ramp_length <= scaled_len;
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            offset_value    <= offset_fin;
            previous_sample <= sample;
            ramp_step       <= step_fin;
            if (ramp_done) begin
              jump_amount <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers, the percent scaling and the serial divider.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sample <= soc_sample;
      end
      ST_EVAL: begin
        delta_nz <= (delta != 34'sd0);
        range    <= 15'(range_val);
      end
      ST_MUL_SCALE: begin
        div_q <= DIVIDEND_BITS'(product[SCALE_BITS-1:0]);
      end
      ST_DIV_SCALE: begin
        div_q <= DIVIDEND_BITS'(product[RECIP_SHIFT +: SCALE_BITS]);
      end
      ST_MUL_RAMP: begin
        div_q   <= product;
        div_rem <= '0;
        div_d   <= ramp_length;
        div_cnt <= 6'(DIVIDEND_BITS);
      end
      ST_DIV_RAMP: begin
        div_q   <= {div_q[DIVIDEND_BITS-2:0], div_ge};
        div_rem <= div_rem_next;
        div_cnt <= div_cnt - 6'd1;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || out_ready)) begin
      smoothed_soc <= smoothed_fin;
      offset_now   <= offset_fin;
    end
  end

endmodule

`default_nettype wire
